/* rtl/core/i2cm_pkg.sv */
// Shared types, phase codes and constants of the I2C master transaction engine.
package i2cm_pkg;

  localparam int BufDepthDefault    = 256;
  localparam int AddrBytesMaxDefault = 2;

  localparam int PhaseW = 4;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [PhaseW-1:0] PH_IDLE       = 4'd0;
  localparam logic [PhaseW-1:0] PH_START_A    = 4'd1;
  localparam logic [PhaseW-1:0] PH_START_B    = 4'd2;
  localparam logic [PhaseW-1:0] PH_TX_HI      = 4'd3;
  localparam logic [PhaseW-1:0] PH_TX_LO      = 4'd4;
  localparam logic [PhaseW-1:0] PH_ACK_HI     = 4'd5;
  localparam logic [PhaseW-1:0] PH_ACK_SAMPLE = 4'd6;
  localparam logic [PhaseW-1:0] PH_RS_A       = 4'd7;
  localparam logic [PhaseW-1:0] PH_RS_B       = 4'd8;
  localparam logic [PhaseW-1:0] PH_RS_C       = 4'd9;
  localparam logic [PhaseW-1:0] PH_RX_HI      = 4'd10;
  localparam logic [PhaseW-1:0] PH_RX_SAMPLE  = 4'd11;
  localparam logic [PhaseW-1:0] PH_MACK_HI    = 4'd12;
  localparam logic [PhaseW-1:0] PH_MACK_LO    = 4'd13;
  localparam logic [PhaseW-1:0] PH_STOP_A     = 4'd14;
  localparam logic [PhaseW-1:0] PH_STOP_B     = 4'd15;

  localparam logic [1:0] KIND_SLAVE_W = 2'd0;
  localparam logic [1:0] KIND_REG     = 2'd1;
  localparam logic [1:0] KIND_SLAVE_R = 2'd2;
  localparam logic [1:0] KIND_DATA    = 2'd3;

  localparam logic [7:0] MsbMask    = 8'h80;
  localparam logic [7:0] WriteMask  = 8'hfe;
  localparam logic [7:0] ReadBit    = 8'h01;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  slave_addr;
    logic [15:0] reg_addr;
    logic [1:0]  reg_addr_len;
    logic [7:0]  data_len;
    logic [7:0]  buffer_index;
    logic [7:0]  write_byte;
    logic        sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [7:0] byte_count;
    logic       nack_seen;
  } result_t;

endpackage

/* rtl/core/i2cm_if.sv */
// Valid/ready channel interfaces for the input items and the result items.
interface i2cm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  slave_addr;
  logic [15:0] reg_addr;
  logic [1:0]  reg_addr_len;
  logic [7:0]  data_len;
  logic [7:0]  buffer_index;
  logic [7:0]  write_byte;
  logic        sda_in;

  modport source (
    output valid, op, slave_addr, reg_addr, reg_addr_len, data_len, buffer_index,
           write_byte, sda_in,
    input  ready
  );
  modport sink (
    input  valid, op, slave_addr, reg_addr, reg_addr_len, data_len, buffer_index,
           write_byte, sda_in,
    output ready
  );
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda;
  logic       busy_res;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       done_res;
  logic [7:0] byte_count;
  logic       nack_seen;

  modport source (
    output valid, scl, sda, busy_res, read_valid, read_byte, done_res, byte_count,
           nack_seen,
    input  ready
  );
  modport sink (
    input  valid, scl, sda, busy_res, read_valid, read_byte, done_res, byte_count,
           nack_seen,
    output ready
  );
endinterface

/* rtl/core/i2c_master_transaction_engine_unit.sv */
// Top level of the I2C master transaction engine: handshakes, result register, checks.
//
//   Channel  Direction  Moves
//   in_i     sink       one item: tick, buffer load, start write or start read
//   out_o    source     one result item per input item: line levels and status
//
// Every accepted item produces exactly one result item, registered and shown on
// out_o in the cycle after acceptance. One item can be taken every clock cycle;
// the sequencer advances one phase per tick and needs no iteration.
// The write buffer has a registered read port. It is read each cycle at the
// index of the next data byte to send, and a load to that same index is
// forwarded, so the fetched byte is always ready for the following item.
// Reset puts the lines high and the sequencer idle; the buffer contents are
// not cleared, and a slot must be loaded before it is sent.
// While a result waits on out_o, a new item is still taken as long as out_o is
// ready to take the waiting one in the same cycle.
module i2c_master_transaction_engine_unit import i2cm_pkg::*; #(
  parameter int BUF_DEPTH      = BufDepthDefault,
  parameter int ADDR_BYTES_MAX = AddrBytesMaxDefault
) (
  input logic         clk_i,
  input logic         rst_ni,
  i2cm_in_if.sink     in_i,
  i2cm_out_if.source  out_o
);

  localparam int AW  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int ABW = $clog2(ADDR_BYTES_MAX + 1);

  item_t         item;
  result_t       res;
  result_t       res_q;
  logic          out_valid_q;
  logic          accept;
  logic          load_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    buf_data;

  // Pack the input item so the sequencer sees one bundle.
  assign item = '{
    op:           in_i.op,
    slave_addr:   in_i.slave_addr,
    reg_addr:     in_i.reg_addr,
    reg_addr_len: in_i.reg_addr_len,
    data_len:     in_i.data_len,
    buffer_index: in_i.buffer_index,
    write_byte:   in_i.write_byte,
    sda_in:       in_i.sda_in
  };

  // The result register empties in the same cycle as it refills.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Loads beyond the buffer are dropped; loads during a transaction are stored.
  assign load_en = accept && (in_i.op == OP_LOAD) && (32'(in_i.buffer_index) < BUF_DEPTH);

  i2cm_buf #(
    .BUF_DEPTH (BUF_DEPTH),
    .AW        (AW)
  ) u_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (load_en),
    .wr_addr_i (in_i.buffer_index[AW-1:0]),
    .wr_data_i (in_i.write_byte),
    .rd_addr_i (rd_addr),
    .rd_data_o (buf_data)
  );

  i2cm_seq #(
    .BUF_DEPTH      (BUF_DEPTH),
    .ADDR_BYTES_MAX (ADDR_BYTES_MAX),
    .AW             (AW),
    .ABW            (ABW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item),
    .buf_data_i (buf_data),
    .rd_addr_o  (rd_addr),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.scl        = res_q.scl;
  assign out_o.sda        = res_q.sda;
  assign out_o.busy_res   = res_q.busy_res;
  assign out_o.read_valid = res_q.read_valid;
  assign out_o.read_byte  = res_q.read_byte;
  assign out_o.done_res   = res_q.done_res;
  assign out_o.byte_count = res_q.byte_count;
  assign out_o.nack_seen  = res_q.nack_seen;

  // An accepted item always leaves a result waiting in the next cycle.
  a_accept_gives_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni) accept |=> out_o.valid
  ) else $error("accepted item left no result");

  // Completion always returns the sequencer to idle.
  a_done_not_busy : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_o.valid && out_o.done_res) |-> !out_o.busy_res
  ) else $error("done reported while still busy");

  // A received byte and a completion never share one result.
  a_rx_not_done : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_o.valid && out_o.read_valid) |-> (!out_o.done_res && out_o.busy_res)
  ) else $error("received byte reported outside a transaction");

  // A missing acknowledge is only ever reported together with completion.
  a_nack_with_done : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_o.valid && out_o.nack_seen) |-> out_o.done_res
  ) else $error("nack reported without done");

endmodule

/* rtl/core/i2cm_buf.sv */
// Write data buffer: one write port, one registered read port with write forwarding.
module i2cm_buf import i2cm_pkg::*; #(
  parameter int BUF_DEPTH = BufDepthDefault,
  parameter int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rd_q;
  logic [7:0] fwd_q;
  logic       hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q  <= mem[rd_addr_i];
    fwd_q <= wr_data_i;
  end

  // A write to the entry being read this cycle is not yet in rd_q.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = hit_q ? fwd_q : rd_q;

endmodule

/* rtl/core/i2cm_seq.sv */
// Bit-level sequencer: transaction state registers and the per-item next-state logic.
module i2cm_seq import i2cm_pkg::*; #(
  parameter int BUF_DEPTH      = BufDepthDefault,
  parameter int ADDR_BYTES_MAX = AddrBytesMaxDefault,
  parameter int AW             = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1,
  parameter int ABW            = $clog2(ADDR_BYTES_MAX + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  item_t         item_i,
  input  logic [7:0]    buf_data_i,
  output logic [AW-1:0] rd_addr_o,
  output result_t       res_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [1:0]        kind_q, kind_d;
  logic [2:0]        bitcnt_q, bitcnt_d;
  logic [7:0]        bytecnt_q, bytecnt_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [7:0]        shift_q, shift_d;
  logic [15:0]       addr_q, addr_d;
  logic [ABW-1:0]    aleft_q, aleft_d;
  logic              is_read_q, is_read_d;
  logic [7:0]        slave_q, slave_d;
  logic [7:0]        len_q, len_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              nack_q, nack_d;

  logic              tx_go;
  logic [1:0]        tx_kind;
  logic [7:0]        tx_byte;
  logic              stop_go;
  logic              rx_go;
  logic [7:0]        cnt_inc;
  logic [7:0]        rx_shift;
  logic [ABW-1:0]    alen_sat;

  assign cnt_inc  = bytecnt_q + 8'd1;
  assign rx_shift = {shift_q[6:0], item_i.sda_in};
  assign alen_sat = (32'(item_i.reg_addr_len) > ADDR_BYTES_MAX) ?
                    ABW'(ADDR_BYTES_MAX) : ABW'(item_i.reg_addr_len);

  always_comb begin
    phase_d   = phase_q;
    kind_d    = kind_q;
    bitcnt_d  = bitcnt_q;
    bytecnt_d = bytecnt_q;
    ptr_d     = ptr_q;
    shift_d   = shift_q;
    addr_d    = addr_q;
    aleft_d   = aleft_q;
    is_read_d = is_read_q;
    slave_d   = slave_q;
    len_d     = len_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    nack_d    = nack_q;
    tx_go     = 1'b0;
    tx_kind   = KIND_DATA;
    tx_byte   = buf_data_i;
    stop_go   = 1'b0;
    rx_go     = 1'b0;
    res_o     = '0;

    if (accept_i) begin
      case (item_i.op)
        OP_LOAD: begin
          // The buffer write itself is done by the buffer module.
        end
        OP_WRITE, OP_READ: begin
          if (phase_q == PH_IDLE) begin
            slave_d   = item_i.slave_addr;
            addr_d    = item_i.reg_addr;
            aleft_d   = alen_sat;
            is_read_d = (item_i.op == OP_READ);
            len_d     = item_i.data_len;
            bytecnt_d = '0;
            ptr_d     = '0;
            nack_d    = 1'b0;
            if (item_i.data_len == 8'd0) begin
              res_o.done_res = 1'b1;
            end else begin
              phase_d = PH_START_A;
            end
          end
        end
        default: begin
          case (phase_q)
            PH_START_A: begin
              sda_d   = 1'b0;
              phase_d = PH_START_B;
            end
            PH_START_B: begin
              scl_d   = 1'b0;
              tx_go   = 1'b1;
              tx_kind = KIND_SLAVE_W;
              tx_byte = slave_q & WriteMask;
            end
            PH_TX_HI: begin
              scl_d   = 1'b1;
              phase_d = PH_TX_LO;
            end
            PH_TX_LO: begin
              scl_d = 1'b0;
              if (bitcnt_q != 3'd0) begin
                bitcnt_d = bitcnt_q - 3'd1;
                shift_d  = {shift_q[6:0], 1'b0};
                sda_d    = shift_q[6];
                phase_d  = PH_TX_HI;
              end else begin
                sda_d   = 1'b1;
                phase_d = PH_ACK_HI;
              end
            end
            PH_ACK_HI: begin
              scl_d   = 1'b1;
              phase_d = PH_ACK_SAMPLE;
            end
            PH_ACK_SAMPLE: begin
              scl_d = 1'b0;
              if (item_i.sda_in) begin
                nack_d  = 1'b1;
                stop_go = 1'b1;
              end else if (kind_q == KIND_SLAVE_R) begin
                rx_go = 1'b1;
              end else if (kind_q == KIND_DATA) begin
                bytecnt_d = cnt_inc;
                if (cnt_inc == len_q) begin
                  stop_go = 1'b1;
                end else begin
                  tx_go = 1'b1;
                end
              end else if (aleft_q != '0) begin
                // Register address goes out least significant byte first.
                tx_go   = 1'b1;
                tx_kind = KIND_REG;
                tx_byte = addr_q[7:0];
                addr_d  = {8'd0, addr_q[15:8]};
                aleft_d = aleft_q - ABW'(1);
              end else if (is_read_q) begin
                sda_d   = 1'b1;
                phase_d = PH_RS_A;
              end else begin
                tx_go = 1'b1;
              end
            end
            PH_RS_A: begin
              scl_d   = 1'b1;
              phase_d = PH_RS_B;
            end
            PH_RS_B: begin
              sda_d   = 1'b0;
              phase_d = PH_RS_C;
            end
            PH_RS_C: begin
              scl_d   = 1'b0;
              tx_go   = 1'b1;
              tx_kind = KIND_SLAVE_R;
              tx_byte = slave_q | ReadBit;
            end
            PH_RX_HI: begin
              scl_d   = 1'b1;
              phase_d = PH_RX_SAMPLE;
            end
            PH_RX_SAMPLE: begin
              scl_d   = 1'b0;
              shift_d = rx_shift;
              if (bitcnt_q != 3'd0) begin
                bitcnt_d = bitcnt_q - 3'd1;
                phase_d  = PH_RX_HI;
              end else begin
                res_o.read_valid = 1'b1;
                res_o.read_byte  = rx_shift;
                bytecnt_d        = cnt_inc;
                sda_d            = (cnt_inc == len_q);
                phase_d          = PH_MACK_HI;
              end
            end
            PH_MACK_HI: begin
              scl_d   = 1'b1;
              phase_d = PH_MACK_LO;
            end
            PH_MACK_LO: begin
              scl_d = 1'b0;
              if (bytecnt_q == len_q) begin
                stop_go = 1'b1;
              end else begin
                rx_go = 1'b1;
              end
            end
            PH_STOP_A: begin
              scl_d   = 1'b1;
              phase_d = PH_STOP_B;
            end
            PH_STOP_B: begin
              sda_d            = 1'b1;
              phase_d          = PH_IDLE;
              res_o.done_res   = 1'b1;
              res_o.nack_seen  = nack_q;
              res_o.byte_count = (is_read_q && nack_q) ? 8'd0 : bytecnt_q;
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
      endcase
    end

    if (tx_go) begin
      kind_d   = tx_kind;
      shift_d  = tx_byte;
      bitcnt_d = 3'd7;
      sda_d    = |(tx_byte & MsbMask);
      phase_d  = PH_TX_HI;
      // Data bytes leave the buffer in order, so the pointer just moves on.
      if (tx_kind == KIND_DATA) begin
        ptr_d = (32'(ptr_q) == BUF_DEPTH - 1) ? '0 : ptr_q + AW'(1);
      end
    end
    if (stop_go) begin
      sda_d   = 1'b0;
      phase_d = PH_STOP_A;
    end
    if (rx_go) begin
      sda_d    = 1'b1;
      shift_d  = '0;
      bitcnt_d = 3'd7;
      phase_d  = PH_RX_HI;
    end

    res_o.scl      = scl_d;
    res_o.sda      = sda_d;
    res_o.busy_res = (phase_d != PH_IDLE);
  end

  assign rd_addr_o = ptr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      kind_q    <= KIND_SLAVE_W;
      bitcnt_q  <= '0;
      bytecnt_q <= '0;
      ptr_q     <= '0;
      shift_q   <= '0;
      addr_q    <= '0;
      aleft_q   <= '0;
      is_read_q <= 1'b0;
      slave_q   <= '0;
      len_q     <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      nack_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      kind_q    <= kind_d;
      bitcnt_q  <= bitcnt_d;
      bytecnt_q <= bytecnt_d;
      ptr_q     <= ptr_d;
      shift_q   <= shift_d;
      addr_q    <= addr_d;
      aleft_q   <= aleft_d;
      is_read_q <= is_read_d;
      slave_q   <= slave_d;
      len_q     <= len_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      nack_q    <= nack_d;
    end
  end

endmodule
